/* rtl/point_gate_extreme_tracker_defines.svh */
// ----------------------------------------------------------------------------
// point gate extreme tracker assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef POINT_GATE_EXTREME_TRACKER_DEFINES_SVH
`define POINT_GATE_EXTREME_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

`define PGET_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pget check failed");

`define PGET_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pget check failed");

`else

`define PGET_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define PGET_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/pget_pkg.sv */
// ----------------------------------------------------------------------------
// pget_pkg
// shared types and constants of the point gate extreme tracker
// ----------------------------------------------------------------------------
package pget_pkg;

  localparam int COORD_BITS = 16;
  localparam int CFG_BITS   = 15;
  localparam int MAG_BITS   = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;

  localparam logic [CFG_BITS-1:0] HEIGHT_LIMIT_RESET   = CFG_BITS'(256);
  localparam logic [CFG_BITS-1:0] HORIZON_RADIUS_RESET = CFG_BITS'(1280);

  typedef enum logic [0:0] {
    CFG_HEIGHT_LIMIT   = 1'b0,
    CFG_HORIZON_RADIUS = 1'b1
  } cfg_index_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   point_invalid;
    logic   frame_first;
    logic   frame_last;
  } point_t;

  typedef struct packed {
    logic   accepted;
    logic   frame_done;
    coord_t center_x;
    coord_t center_y;
    coord_t least_x_px;
    coord_t least_x_py;
    coord_t most_x_px;
    coord_t most_x_py;
    coord_t least_y_px;
    coord_t least_y_py;
    coord_t most_y_px;
    coord_t most_y_py;
  } result_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
  } ext_t;

  typedef struct packed {
    logic               z_ok;
    logic [SQ_BITS-1:0] x_sq;
    logic [SQ_BITS-1:0] y_sq;
    logic [SQ_BITS-1:0] r_sq;
  } gate_t;

endpackage

/* rtl/point_gate_extreme_tracker.sv */
// ----------------------------------------------------------------------------
// point_gate_extreme_tracker
// gates 3-d points by height and planar radius and tracks four extreme points
// ----------------------------------------------------------------------------
// Takes one point per clock while the result side does not stall, and gives one
// result word per point. The input register, the square register and the result
// register form the pipeline; the compare-and-replace of the four extremes is
// combinational between the square register and the extreme registers, so a new
// point can follow in every cycle. A stall on the result side backs up through
// the three registers before the point side sees a stall.
`include "point_gate_extreme_tracker_defines.svh"

module point_gate_extreme_tracker
  import pget_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  cfg_index_t          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                point_valid,
  output logic                point_stall,
  input  point_t              point,
  output logic                result_valid,
  input  logic                result_stall,
  output result_t             result
);

  logic [CFG_BITS-1:0] height_limit;
  logic [CFG_BITS-1:0] horizon_radius;

  logic    a_valid;
  point_t  a_point;
  logic    b_valid;
  point_t  b_point;
  gate_t   gate;

  logic    o_free;
  logic    b_free;
  logic    a_free;
  logic    b_move;
  logic    a_move;

  logic    seeded;
  logic    seeded_next;
  ext_t    least_x;
  ext_t    most_x;
  ext_t    least_y;
  ext_t    most_y;
  ext_t    least_x_next;
  ext_t    most_x_next;
  ext_t    least_y_next;
  ext_t    most_y_next;

  ext_t    cur;
  ext_t    base_lx;
  ext_t    base_mx;
  ext_t    base_ly;
  ext_t    base_my;
  logic    seeded_base;
  logic    seed_now;
  logic    acc;
  logic signed [COORD_BITS:0] sum_x;
  logic signed [COORD_BITS:0] sum_y;
  result_t result_next;

  // handshake chain
  always_comb begin
    o_free      = !result_valid || !result_stall;
    b_free      = !b_valid || o_free;
    a_free      = !a_valid || b_free;
    b_move      = b_valid && o_free;
    a_move      = a_valid && b_free;
    point_stall = !a_free;
  end

  pget_gate u_gate (
    .clk            (clk),
    .en             (a_move),
    .pt             (a_point),
    .height_limit   (height_limit),
    .horizon_radius (horizon_radius),
    .gate           (gate)
  );

  // seeding, gate decision and extreme update
  always_comb begin
    cur.px      = b_point.point_x;
    cur.py      = b_point.point_y;
    seeded_base = seeded && !b_point.frame_first;
    seed_now    = !b_point.point_invalid && !seeded_base;
    seeded_next = seeded_base || !b_point.point_invalid;
    base_lx     = seed_now ? cur : least_x;
    base_mx     = seed_now ? cur : most_x;
    base_ly     = seed_now ? cur : least_y;
    base_my     = seed_now ? cur : most_y;
    acc = !b_point.point_invalid && gate.z_ok &&
          ((SUM_BITS'(gate.x_sq) + SUM_BITS'(gate.y_sq)) < SUM_BITS'(gate.r_sq));
    least_x_next = (acc && (cur.px <= base_lx.px)) ? cur : base_lx;
    most_x_next  = (acc && (cur.px >= base_mx.px)) ? cur : base_mx;
    least_y_next = (acc && (cur.py <= base_ly.py)) ? cur : base_ly;
    most_y_next  = (acc && (cur.py >= base_my.py)) ? cur : base_my;
    sum_x = {least_x_next.px[COORD_BITS-1], least_x_next.px} +
            {least_y_next.px[COORD_BITS-1], least_y_next.px};
    sum_y = {least_x_next.py[COORD_BITS-1], least_x_next.py} +
            {least_y_next.py[COORD_BITS-1], least_y_next.py};
    result_next.accepted   = acc;
    result_next.frame_done = b_point.frame_last;
    result_next.center_x   = sum_x[COORD_BITS:1];
    result_next.center_y   = sum_y[COORD_BITS:1];
    result_next.least_x_px = least_x_next.px;
    result_next.least_x_py = least_x_next.py;
    result_next.most_x_px  = most_x_next.px;
    result_next.most_x_py  = most_x_next.py;
    result_next.least_y_px = least_y_next.px;
    result_next.least_y_py = least_y_next.py;
    result_next.most_y_px  = most_y_next.px;
    result_next.most_y_py  = most_y_next.py;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      height_limit   <= HEIGHT_LIMIT_RESET;
      horizon_radius <= HORIZON_RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEIGHT_LIMIT:   height_limit   <= cfg_data;
        CFG_HORIZON_RADIUS: horizon_radius <= cfg_data;
        default:            height_limit   <= height_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
      seeded       <= 1'b0;
      least_x      <= '0;
      most_x       <= '0;
      least_y      <= '0;
      most_y       <= '0;
    end else begin
      if (a_free) begin
        a_valid <= point_valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (o_free) begin
        result_valid <= b_valid;
      end
      if (b_move) begin
        seeded  <= seeded_next;
        least_x <= least_x_next;
        most_x  <= most_x_next;
        least_y <= least_y_next;
        most_y  <= most_y_next;
      end
    end
  end

  // payload words
  always_ff @(posedge clk) begin
    if (point_valid && a_free) begin
      a_point <= point;
    end
    if (a_move) begin
      b_point <= a_point;
    end
    if (b_move) begin
      result <= result_next;
    end
  end

  `PGET_ASSERT_IMPLIES(a_x_order, clk, rst, result_valid, result.least_x_px <= result.most_x_px)
  `PGET_ASSERT_IMPLIES(a_y_order, clk, rst, result_valid, result.least_y_py <= result.most_y_py)
  `PGET_ASSERT_IMPLIES(a_stall_full, clk, rst, point_stall, a_valid && b_valid && result_stall)
  `PGET_ASSERT_NEXT(a_accept_seeds, clk, rst, b_move && acc, seeded)

endmodule

/* rtl/pget_gate.sv */
// ----------------------------------------------------------------------------
// pget_gate
// height check and registered squares for the planar horizon check
// ----------------------------------------------------------------------------
module pget_gate
  import pget_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  point_t              pt,
  input  logic [CFG_BITS-1:0] height_limit,
  input  logic [CFG_BITS-1:0] horizon_radius,
  output gate_t               gate
);

  logic [COORD_BITS-1:0] abs_x;
  logic [COORD_BITS-1:0] abs_y;
  logic [COORD_BITS-1:0] abs_z;
  logic [MAG_BITS-1:0]   mag_x;
  logic [MAG_BITS-1:0]   mag_y;
  logic [MAG_BITS-1:0]   mag_z;
  logic [MAG_BITS-1:0]   mag_r;
  logic [MAG_BITS-1:0]   mag_h;
  gate_t                 gate_next;

  always_comb begin
    abs_x = pt.point_x[COORD_BITS-1] ? (~pt.point_x + 1'b1) : pt.point_x;
    abs_y = pt.point_y[COORD_BITS-1] ? (~pt.point_y + 1'b1) : pt.point_y;
    abs_z = pt.point_z[COORD_BITS-1] ? (~pt.point_z + 1'b1) : pt.point_z;
    mag_x = MAG_BITS'(abs_x);
    mag_y = MAG_BITS'(abs_y);
    mag_z = MAG_BITS'(abs_z);
    mag_r = MAG_BITS'(horizon_radius);
    mag_h = MAG_BITS'(height_limit);
    gate_next.z_ok = mag_z < mag_h;
    gate_next.x_sq = mag_x * mag_x;
    gate_next.y_sq = mag_y * mag_y;
    gate_next.r_sq = mag_r * mag_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gate <= gate_next;
    end
  end

endmodule
